// ===== rtl/multiturn_angle_velocity_tracker_assert.svh =====
// ----------------------------------------------------------------------------
// assertion macros for the multiturn angle and velocity tracker
// ----------------------------------------------------------------------------
`ifndef MULTITURN_ANGLE_VELOCITY_TRACKER_ASSERT_SVH
`define MULTITURN_ANGLE_VELOCITY_TRACKER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define AVT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define AVT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/avt_pkg.sv =====
// ----------------------------------------------------------------------------
// avt_pkg
// shared widths, codes and types of the multiturn angle and velocity tracker
// ----------------------------------------------------------------------------
package avt_pkg;

    localparam int ANGLE_BITS    = 12;
    localparam int TURN_BITS     = 32;
    localparam int TIME_BITS     = 32;
    localparam int TOTAL_BITS    = TURN_BITS + ANGLE_BITS;
    localparam int VEL_BITS      = 32;
    localparam int WRAP_BITS     = 12;
    localparam int INTERVAL_BITS = 20;
    localparam int CFG_DATA_BITS = 20;
    localparam int CFG_IDX_BITS  = 1;
    localparam int KIND_BITS     = 2;

    // count delta magnitude and its scaling by one million
    localparam int MAG_BITS  = TURN_BITS + ANGLE_BITS;
    localparam int US_BITS   = 20;
    localparam int MUL_SPLIT = MAG_BITS / 2;
    localparam int PART_BITS = (MAG_BITS - MUL_SPLIT) + US_BITS;
    localparam int PROD_BITS = MAG_BITS + US_BITS;

    localparam logic [US_BITS-1:0]       US_PER_S       = 20'd1000000;
    localparam logic [WRAP_BITS-1:0]     WRAP_RESET     = 12'd3276;
    localparam logic [INTERVAL_BITS-1:0] INTERVAL_RESET = 20'd1000;

    localparam logic [PROD_BITS-1:0] POS_LIMIT = 64'h0000_0000_7FFF_FFFF;
    localparam logic [PROD_BITS-1:0] NEG_LIMIT = 64'h0000_0000_8000_0000;

    localparam logic [CFG_IDX_BITS-1:0] CFG_WRAP_THRESHOLD   = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DEFAULT_INTERVAL = 1'd1;

    localparam logic [KIND_BITS-1:0] KIND_PRIME    = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_ANGLE    = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_VELOCITY = 2'd2;

    // classified item handed from the front to the back
    typedef struct packed {
        logic [ANGLE_BITS-1:0] angle;
        logic [TURN_BITS-1:0]  turns;
        logic                  is_vel;
        logic                  neg;
        logic [MAG_BITS-1:0]   mag;
        logic [TIME_BITS-1:0]  divisor;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_DIV,
        ST_DONE
    } t_back_state;

endpackage

// ===== rtl/avt_in_if.sv =====
// ----------------------------------------------------------------------------
// avt_in_if
// input channel: angle samples and velocity requests
// ----------------------------------------------------------------------------
interface avt_in_if;
    import avt_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [KIND_BITS-1:0]  kind;
    logic [ANGLE_BITS-1:0] angle_count;
    logic [TIME_BITS-1:0]  time_us;

    modport source (output valid, kind, angle_count, time_us, input ready);
    modport sink (input valid, kind, angle_count, time_us, output ready);
endinterface

// ===== rtl/avt_out_if.sv =====
// ----------------------------------------------------------------------------
// avt_out_if
// result channel: angle, turns, total count and velocity
// ----------------------------------------------------------------------------
interface avt_out_if;
    import avt_pkg::*;

    logic                         valid;
    logic                         ready;
    logic [ANGLE_BITS-1:0]        angle_out;
    logic signed [TURN_BITS-1:0]  turns_out;
    logic signed [TOTAL_BITS-1:0] total_count;
    logic signed [VEL_BITS-1:0]   velocity_cps;
    logic                         velocity_valid;

    modport source (
        output valid, angle_out, turns_out, total_count, velocity_cps, velocity_valid,
        input ready
    );
    modport sink (
        input valid, angle_out, turns_out, total_count, velocity_cps, velocity_valid,
        output ready
    );
endinterface

// ===== rtl/multiturn_angle_velocity_tracker.sv =====
// ----------------------------------------------------------------------------
// multiturn_angle_velocity_tracker
// multiturn angle tracking and velocity estimation for an absolute encoder
//
// i_in carries kind (prime, angle update, velocity), a 12-bit angle and a
// microsecond timestamp; every accepted item yields one result on o_out with
// angle, signed turns, total count and, for a velocity item, counts per second.
// wrap threshold and default interval are written through i_cfg_*; the user
// must do so only while idle, the block does not enforce it. the front updates
// turn and snapshot state on the transfer itself and queues a command; the back
// turns it into a result. prime and angle items pass through the queue and
// the output register, one item per cycle while o_out is ready and the back
// is idle. velocity items: a low and a high multiply step, then a bit-serial
// divider over a 64-bit quotient; no new command is taken until the result is loaded.
// i_in stays ready while the command queue has room, so items keep flowing
// while the divider works and while a result waits in the output register.
// when o_out stalls, the output register holds its result, the back stops and
// the queue fills, then i_in drops ready.
// reset clears turns, snapshots and queue, and loads the register defaults.
// ----------------------------------------------------------------------------
`include "multiturn_angle_velocity_tracker_assert.svh"

module multiturn_angle_velocity_tracker #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    avt_in_if.sink                            i_in,
    avt_out_if.source                         o_out,
    input  logic                              i_cfg_we,
    input  logic [avt_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [avt_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);
    import avt_pkg::*;

    t_q_status q_stat;
    t_cmd      push_cmd;
    t_cmd      head_cmd;
    logic      q_push;
    logic      q_pop;

    avt_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_q_stat   (q_stat),
        .o_push     (q_push),
        .o_cmd      (push_cmd)
    );

    avt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (push_cmd),
        .i_pop   (q_pop),
        .o_cmd   (head_cmd),
        .o_stat  (q_stat)
    );

    avt_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (head_cmd),
        .i_q_stat (q_stat),
        .o_pop    (q_pop),
        .o_out    (o_out)
    );

    `AVT_ASSERT_SAME(a_no_pop_empty, i_clk, i_rst_n, q_pop, !q_stat.empty, "pop from empty queue")
    `AVT_ASSERT_SAME(a_no_push_full, i_clk, i_rst_n, q_push, !q_stat.full, "push into full queue")
    `AVT_ASSERT_NEXT(a_push_fills, i_clk, i_rst_n, q_push && q_stat.empty, !q_stat.empty, "push lost")
    `AVT_ASSERT_SAME(a_vel_zero, i_clk, i_rst_n, o_out.valid && !o_out.velocity_valid, o_out.velocity_cps == '0, "stray velocity")

endmodule

// ===== rtl/avt_front.sv =====
// ----------------------------------------------------------------------------
// avt_front
// accepts items, tracks turns and snapshots, and queues one command per item
// ----------------------------------------------------------------------------
module avt_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    avt_in_if.sink                               i_in,
    input  logic                                 i_cfg_we,
    input  logic [avt_pkg::CFG_IDX_BITS-1:0]     i_cfg_idx,
    input  logic [avt_pkg::CFG_DATA_BITS-1:0]    i_cfg_data,
    input  avt_pkg::t_q_status                   i_q_stat,
    output logic                                 o_push,
    output avt_pkg::t_cmd                        o_cmd
);
    import avt_pkg::*;

    logic [WRAP_BITS-1:0]     r_wrap;
    logic [INTERVAL_BITS-1:0] r_interval;
    logic [ANGLE_BITS-1:0]    r_last_angle, n_last_angle;
    logic [TIME_BITS-1:0]     r_last_time, n_last_time;
    logic [TURN_BITS-1:0]     r_turns, n_turns;
    logic [ANGLE_BITS-1:0]    r_snap_angle, n_snap_angle;
    logic [TIME_BITS-1:0]     r_snap_time, n_snap_time;
    logic [TURN_BITS-1:0]     r_snap_turns, n_snap_turns;

    logic                   accept;
    logic [ANGLE_BITS:0]    angle_diff;
    logic [ANGLE_BITS:0]    angle_abs;
    logic                   wrap_hit;
    logic [TIME_BITS-1:0]   elapsed;
    logic [TURN_BITS-1:0]   turn_diff;
    logic [ANGLE_BITS:0]    snap_diff;
    logic [MAG_BITS:0]      delta;
    logic [MAG_BITS:0]      delta_abs;
    logic [TIME_BITS-1:0]   divisor;

    assign i_in.ready = !i_q_stat.full;
    assign accept     = i_in.valid && i_in.ready;
    assign o_push     = accept;

    always_comb begin
        angle_diff = {1'b0, i_in.angle_count} - {1'b0, r_last_angle};
        angle_abs  = angle_diff[ANGLE_BITS] ? (~angle_diff + 1'b1) : angle_diff;
        wrap_hit   = angle_abs > {1'b0, r_wrap};

        // signed count delta since the last velocity snapshot
        elapsed   = r_last_time - r_snap_time;
        turn_diff = r_turns - r_snap_turns;
        snap_diff = {1'b0, r_last_angle} - {1'b0, r_snap_angle};
        delta     = {turn_diff[TURN_BITS-1], turn_diff, {ANGLE_BITS{1'b0}}}
                  + {{(MAG_BITS - ANGLE_BITS){snap_diff[ANGLE_BITS]}}, snap_diff};
        delta_abs = delta[MAG_BITS] ? (~delta + 1'b1) : delta;

        if (elapsed != '0) begin
            divisor = elapsed;
        end else if (r_interval == '0) begin
            divisor = TIME_BITS'(1);
        end else begin
            divisor = TIME_BITS'(r_interval);
        end

        n_last_angle = r_last_angle;
        n_last_time  = r_last_time;
        n_turns      = r_turns;
        n_snap_angle = r_snap_angle;
        n_snap_time  = r_snap_time;
        n_snap_turns = r_snap_turns;

        unique case (i_in.kind)
            KIND_PRIME: begin
                n_last_angle = i_in.angle_count;
                n_snap_angle = i_in.angle_count;
                n_last_time  = i_in.time_us;
                n_snap_time  = i_in.time_us;
            end
            KIND_ANGLE: begin
                // turn counter moves against the jump
                if (wrap_hit) begin
                    if (!angle_diff[ANGLE_BITS]) begin
                        n_turns = r_turns - 1'b1;
                    end else begin
                        n_turns = r_turns + 1'b1;
                    end
                end
                n_last_angle = i_in.angle_count;
                n_last_time  = i_in.time_us;
            end
            KIND_VELOCITY: begin
                n_snap_angle = r_last_angle;
                n_snap_turns = r_turns;
                n_snap_time  = r_last_time;
            end
            default: begin
            end
        endcase

        o_cmd.angle   = n_last_angle;
        o_cmd.turns   = n_turns;
        o_cmd.is_vel  = i_in.kind == KIND_VELOCITY;
        o_cmd.neg     = delta[MAG_BITS];
        o_cmd.mag     = delta_abs[MAG_BITS-1:0];
        o_cmd.divisor = divisor;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_angle <= '0;
            r_last_time  <= '0;
            r_turns      <= '0;
            r_snap_angle <= '0;
            r_snap_time  <= '0;
            r_snap_turns <= '0;
        end else if (accept) begin
            r_last_angle <= n_last_angle;
            r_last_time  <= n_last_time;
            r_turns      <= n_turns;
            r_snap_angle <= n_snap_angle;
            r_snap_time  <= n_snap_time;
            r_snap_turns <= n_snap_turns;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wrap     <= WRAP_RESET;
            r_interval <= INTERVAL_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_WRAP_THRESHOLD:   r_wrap     <= i_cfg_data[WRAP_BITS-1:0];
                CFG_DEFAULT_INTERVAL: r_interval <= i_cfg_data[INTERVAL_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== rtl/avt_queue.sv =====
// ----------------------------------------------------------------------------
// avt_queue
// short command queue between the front and the back
// ----------------------------------------------------------------------------
module avt_queue #(
    parameter int DEPTH = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  avt_pkg::t_cmd      i_cmd,
    input  logic               i_pop,
    output avt_pkg::t_cmd      o_cmd,
    output avt_pkg::t_q_status o_stat
);
    import avt_pkg::*;

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);
    localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);

    t_cmd                r_slot [DEPTH];
    logic [PTR_BITS-1:0] r_wr, n_wr;
    logic [PTR_BITS-1:0] r_rd, n_rd;
    logic [CNT_BITS-1:0] r_cnt, n_cnt;

    assign o_stat.full  = r_cnt == FULL_CNT;
    assign o_stat.empty = r_cnt == '0;
    assign o_cmd        = r_slot[r_rd];

    always_comb begin
        n_wr = r_wr;
        n_rd = r_rd;
        if (i_push) begin
            n_wr = (r_wr == LAST_PTR) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == LAST_PTR) ? '0 : r_rd + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

// ===== rtl/avt_back.sv =====
// ----------------------------------------------------------------------------
// avt_back
// scales the count delta, divides by the interval and drives the result
// ----------------------------------------------------------------------------
module avt_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  avt_pkg::t_cmd      i_cmd,
    input  avt_pkg::t_q_status i_q_stat,
    output logic               o_pop,
    avt_out_if.source          o_out
);
    import avt_pkg::*;

    localparam int STEP_BITS = $clog2(PROD_BITS);
    localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(PROD_BITS - 1);

    t_back_state           r_state, n_state;
    t_cmd                  r_cmd;
    logic [PROD_BITS-1:0]  r_quo;
    logic [TIME_BITS-1:0]  r_rem;
    logic [STEP_BITS-1:0]  r_step;

    logic                  r_out_valid;
    logic [ANGLE_BITS-1:0] r_angle;
    logic [TURN_BITS-1:0]  r_turns;
    logic [VEL_BITS-1:0]   r_vel;
    logic                  r_vel_valid;

    logic                  out_free;
    logic                  load_cmd;
    logic                  load_plain;
    logic                  load_vel;
    logic [PART_BITS-1:0]  mul_a;
    logic [PART_BITS-1:0]  mul_p;
    logic [TIME_BITS:0]    trial;
    logic [TIME_BITS:0]    trial_sub;
    logic                  trial_ge;
    logic [PROD_BITS-1:0]  limit;
    logic [VEL_BITS-1:0]   vel_mag;
    logic [VEL_BITS-1:0]   vel_out;

    assign out_free = !r_out_valid || o_out.ready;

    // one narrow multiplier shared by both halves of the magnitude
    always_comb begin
        if (r_state == ST_MUL_LO) begin
            mul_a = PART_BITS'(r_cmd.mag[MUL_SPLIT-1:0]);
        end else begin
            mul_a = PART_BITS'(r_cmd.mag[MAG_BITS-1:MUL_SPLIT]);
        end
        mul_p = mul_a * PART_BITS'(US_PER_S);
    end

    // restoring division, one quotient bit per cycle
    always_comb begin
        trial     = {r_rem, r_quo[PROD_BITS-1]};
        trial_sub = trial - {1'b0, r_cmd.divisor};
        trial_ge  = trial >= {1'b0, r_cmd.divisor};
    end

    always_comb begin
        limit   = r_cmd.neg ? NEG_LIMIT : POS_LIMIT;
        vel_mag = (r_quo > limit) ? limit[VEL_BITS-1:0] : r_quo[VEL_BITS-1:0];
        vel_out = r_cmd.neg ? (~vel_mag + 1'b1) : vel_mag;
    end

    always_comb begin
        n_state    = r_state;
        o_pop      = 1'b0;
        load_cmd   = 1'b0;
        load_plain = 1'b0;
        load_vel   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_q_stat.empty) begin
                    if (i_cmd.is_vel) begin
                        o_pop    = 1'b1;
                        load_cmd = 1'b1;
                        n_state  = ST_MUL_LO;
                    end else if (out_free) begin
                        o_pop      = 1'b1;
                        load_plain = 1'b1;
                    end
                end
            end
            ST_MUL_LO: n_state = ST_MUL_HI;
            ST_MUL_HI: n_state = ST_DIV;
            ST_DIV: begin
                if (r_step == LAST_STEP) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    load_vel = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_cmd) begin
            r_cmd <= i_cmd;
        end
        case (r_state)
            ST_MUL_LO: r_quo <= PROD_BITS'(mul_p);
            ST_MUL_HI: begin
                r_quo  <= r_quo + {mul_p, {MUL_SPLIT{1'b0}}};
                r_rem  <= '0;
                r_step <= '0;
            end
            ST_DIV: begin
                r_quo  <= {r_quo[PROD_BITS-2:0], trial_ge};
                r_rem  <= trial_ge ? trial_sub[TIME_BITS-1:0] : trial[TIME_BITS-1:0];
                r_step <= r_step + 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_plain || load_vel) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_plain) begin
            r_angle     <= i_cmd.angle;
            r_turns     <= i_cmd.turns;
            r_vel       <= '0;
            r_vel_valid <= 1'b0;
        end else if (load_vel) begin
            r_angle     <= r_cmd.angle;
            r_turns     <= r_cmd.turns;
            r_vel       <= vel_out;
            r_vel_valid <= 1'b1;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.angle_out      = r_angle;
    assign o_out.turns_out      = r_turns;
    assign o_out.total_count    = {r_turns, r_angle};
    assign o_out.velocity_cps   = r_vel;
    assign o_out.velocity_valid = r_vel_valid;

endmodule

// ===== tb/sv/multiturn_angle_velocity_tracker_checker.sv =====
// ----------------------------------------------------------------------------
// multiturn_angle_velocity_tracker_checker
// watches the sample and result channels and the register port, tracks turns,
// snapshots and velocity on its own, and compares every result in order
// ----------------------------------------------------------------------------
module multiturn_angle_velocity_tracker_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    avt_in_if                                 i_in_mon,
    avt_out_if                                i_out_mon,
    input  logic                              i_cfg_we,
    input  logic [avt_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [avt_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    output int                                o_fail_count,
    output int                                o_pending
);
    import avt_pkg::*;

    typedef struct packed {
        logic [ANGLE_BITS-1:0] angle;
        logic [TURN_BITS-1:0]  turns;
        logic [TOTAL_BITS-1:0] total;
        logic [VEL_BITS-1:0]   vel;
        logic                  vel_valid;
    } t_track_result;

    logic [WRAP_BITS-1:0]     wrap_thr;
    logic [INTERVAL_BITS-1:0] dflt_interval;
    logic [ANGLE_BITS-1:0]    cur_angle;
    logic [TIME_BITS-1:0]     cur_stamp;
    logic [TURN_BITS-1:0]     turn_cnt;
    logic [ANGLE_BITS-1:0]    snap_angle;
    logic [TIME_BITS-1:0]     snap_stamp;
    logic [TURN_BITS-1:0]     snap_turns;

    t_track_result expected_track[$];

    // counts per second since the last snapshot, truncated and saturated
    function automatic logic [VEL_BITS-1:0] velocity_since_snap();
        logic [TIME_BITS-1:0]  elapsed;
        logic signed [31:0]    tdiff;
        logic signed [63:0]    tdiff_wide;
        logic signed [63:0]    delta;
        logic [63:0]           mag;
        logic [95:0]           scaled;
        logic [95:0]           lim;
        logic                  neg;
        elapsed = cur_stamp - snap_stamp;
        if (elapsed == '0) begin
            elapsed = (dflt_interval == '0) ? 32'd1 : {12'd0, dflt_interval};
        end
        tdiff = signed'(turn_cnt - snap_turns);
        tdiff_wide = tdiff;
        delta = tdiff_wide * 64'sd4096 + $signed({52'd0, cur_angle})
              - $signed({52'd0, snap_angle});
        neg = delta < 0;
        mag = neg ? 64'(-delta) : 64'(delta);
        scaled = ({32'd0, mag} * 96'd1000000) / {64'd0, elapsed};
        lim = neg ? 96'h8000_0000 : 96'h7FFF_FFFF;
        if (scaled > lim) begin
            scaled = lim;
        end
        return neg ? (32'd0 - scaled[31:0]) : scaled[31:0];
    endfunction

    function automatic t_track_result advance_tracker(
        input logic [KIND_BITS-1:0]  kind,
        input logic [ANGLE_BITS-1:0] angle,
        input logic [TIME_BITS-1:0]  stamp
    );
        t_track_result res;
        int            jump;
        int            mag;
        res = '0;
        case (kind)
            KIND_PRIME: begin
                cur_angle  = angle;
                snap_angle = angle;
                cur_stamp  = stamp;
                snap_stamp = stamp;
            end
            KIND_ANGLE: begin
                jump = int'(angle) - int'(cur_angle);
                mag = (jump < 0) ? -jump : jump;
                // turn counter moves against the jump
                if (mag > int'(wrap_thr)) begin
                    turn_cnt = (jump > 0) ? turn_cnt - 1'b1 : turn_cnt + 1'b1;
                end
                cur_angle = angle;
                cur_stamp = stamp;
            end
            KIND_VELOCITY: begin
                res.vel       = velocity_since_snap();
                res.vel_valid = 1'b1;
                snap_angle    = cur_angle;
                snap_turns    = turn_cnt;
                snap_stamp    = cur_stamp;
            end
            default: begin
            end
        endcase
        res.angle = cur_angle;
        res.turns = turn_cnt;
        res.total = {turn_cnt, cur_angle};
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_track_result exp_res;
        if (!i_rst_n) begin
            wrap_thr      = WRAP_RESET;
            dflt_interval = INTERVAL_RESET;
            cur_angle     = '0;
            cur_stamp     = '0;
            turn_cnt      = '0;
            snap_angle    = '0;
            snap_stamp    = '0;
            snap_turns    = '0;
            expected_track.delete();
            o_fail_count  = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_WRAP_THRESHOLD:   wrap_thr = i_cfg_data[WRAP_BITS-1:0];
                    CFG_DEFAULT_INTERVAL: dflt_interval = i_cfg_data[INTERVAL_BITS-1:0];
                    default: begin
                    end
                endcase
            end
            // results first: a result never belongs to a sample taken on the same edge
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (expected_track.size() == 0) begin
                    $error("result transfer with no sample outstanding");
                    o_fail_count++;
                end else begin
                    exp_res = expected_track.pop_front();
                    if (i_out_mon.angle_out !== exp_res.angle) begin
                        $error("angle_out expected %0d got %0d", exp_res.angle,
                               i_out_mon.angle_out);
                        o_fail_count++;
                    end
                    if (i_out_mon.turns_out !== exp_res.turns) begin
                        $error("turns_out expected %0d got %0d", $signed(exp_res.turns),
                               i_out_mon.turns_out);
                        o_fail_count++;
                    end
                    if (i_out_mon.total_count !== exp_res.total) begin
                        $error("total_count expected %0d got %0d", $signed(exp_res.total),
                               i_out_mon.total_count);
                        o_fail_count++;
                    end
                    if (i_out_mon.velocity_cps !== exp_res.vel) begin
                        $error("velocity_cps expected %0d got %0d", $signed(exp_res.vel),
                               i_out_mon.velocity_cps);
                        o_fail_count++;
                    end
                    if (i_out_mon.velocity_valid !== exp_res.vel_valid) begin
                        $error("velocity_valid expected %0d got %0d", exp_res.vel_valid,
                               i_out_mon.velocity_valid);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                expected_track.push_back(advance_tracker(i_in_mon.kind,
                                                         i_in_mon.angle_count,
                                                         i_in_mon.time_us));
            end
        end
        o_pending = expected_track.size();
    end

endmodule

// ===== tb/sv/multiturn_angle_velocity_tracker_tb.sv =====
// ----------------------------------------------------------------------------
// multiturn_angle_velocity_tracker_tb
// drives angle samples, primes and velocity requests through several register
// settings with random gaps and stalls; a checker beside the block predicts
// and compares every result
// ----------------------------------------------------------------------------
module multiturn_angle_velocity_tracker_tb;
    import avt_pkg::*;

    localparam logic [KIND_BITS-1:0] KIND_SPARE = 2'd3;
    localparam int NUM_PHASES  = 6;
    localparam int PHASE_ITEMS = 280;
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 4000;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     cfg_we;
    logic [CFG_IDX_BITS-1:0]  cfg_idx;
    logic [CFG_DATA_BITS-1:0] cfg_data;
    int                       fail_count;
    int                       pending;
    int                       stall_cycles;

    bit                       idling;
    bit                       hold_req;
    logic [ANGLE_BITS-1:0]    motor_angle;
    logic [TIME_BITS-1:0]     motor_stamp;

    avt_in_if  in_ch();
    avt_out_if out_ch();

    multiturn_angle_velocity_tracker DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    multiturn_angle_velocity_tracker_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever begin
            #10 i_clk = ~i_clk;
        end
    end

    // result side: random stall bursts, plus one long hold-off on request
    initial begin
        out_ch.ready = 1'b0;
        @(negedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else if (idling && $urandom_range(0, 5) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
                @(negedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles == STALL_LIMIT) begin
            $display("multiturn_angle_velocity_tracker test failed");
            $finish;
        end
    end

    // starts and ends at a falling edge
    task automatic offer_sample(
        input logic [KIND_BITS-1:0]  kind,
        input logic [ANGLE_BITS-1:0] angle,
        input logic [TIME_BITS-1:0]  stamp
    );
        if (idling && $urandom_range(0, 4) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.kind        <= kind;
        in_ch.angle_count <= angle;
        in_ch.time_us     <= stamp;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic wait_for_results();
        in_ch.valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
    endtask

    task automatic set_regs(
        input logic [WRAP_BITS-1:0]     thr,
        input logic [INTERVAL_BITS-1:0] interval
    );
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_WRAP_THRESHOLD;
        cfg_data <= CFG_DATA_BITS'(thr);
        @(negedge i_clk);
        cfg_idx  <= CFG_DEFAULT_INTERVAL;
        cfg_data <= interval;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // limits, wraps across zero, threshold edges, saturation, time going back
    task automatic run_directed();
        offer_sample(KIND_SPARE, 12'hABC, 32'h1234_5678);
        offer_sample(KIND_VELOCITY, 12'd0, 32'd0);
        offer_sample(KIND_PRIME, 12'd4095, 32'hFFFF_FFFF);
        offer_sample(KIND_ANGLE, 12'd0, 32'd0);
        offer_sample(KIND_VELOCITY, 12'd4095, 32'hFFFF_FFFF);
        offer_sample(KIND_ANGLE, 12'd4095, 32'd1);
        offer_sample(KIND_ANGLE, 12'd0, 32'd2);
        offer_sample(KIND_ANGLE, 12'd3277, 32'd3);
        offer_sample(KIND_ANGLE, 12'd1, 32'd4);
        offer_sample(KIND_VELOCITY, 12'd0, 32'd0);
        offer_sample(KIND_VELOCITY, 12'd0, 32'd0);
        offer_sample(KIND_ANGLE, 12'd2500, 32'd5);
        offer_sample(KIND_VELOCITY, 12'd0, 32'd0);
        offer_sample(KIND_PRIME, 12'd100, 32'd1000);
        offer_sample(KIND_ANGLE, 12'd200, 32'd500);
        offer_sample(KIND_VELOCITY, 12'd0, 32'd0);
        offer_sample(KIND_SPARE, 12'd4095, 32'hFFFF_FFFF);
        offer_sample(KIND_ANGLE, 12'd0, 32'd0);
        offer_sample(KIND_ANGLE, 12'd3000, 32'd1);
        offer_sample(KIND_VELOCITY, 12'd0, 32'd0);
        wait_for_results();
    endtask

    task automatic run_motion(input int num_items, input int phase);
        int                    pick;
        int                    step;
        logic [KIND_BITS-1:0]  kind;
        logic [ANGLE_BITS-1:0] angle;
        logic [TIME_BITS-1:0]  stamp;
        for (int i = 0; i < num_items; i++) begin
            idling = (phase != NUM_PHASES - 1) && ((i % 96) < 64);
            if (phase == 2 && i == 40) begin
                hold_req = 1'b1;
            end
            if (phase == 3 && i == num_items / 2) begin
                wait_for_results();
            end
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
                motor_angle = 12'($urandom_range(0, 4095));
                motor_stamp = motor_stamp + $urandom_range(0, 50);
                offer_sample(KIND_PRIME, motor_angle, motor_stamp);
            end else if (pick < 62) begin
                if ($urandom_range(0, 11) == 0) begin
                    motor_angle = 12'($urandom_range(0, 4095));
                end else begin
                    step = $urandom_range(0, 1200) - 600;
                    motor_angle = motor_angle + 12'(step);
                end
                step = $urandom_range(0, 99);
                if (step < 10) begin
                    // same timestamp
                end else if (step < 15) begin
                    motor_stamp = $urandom;
                end else begin
                    motor_stamp = motor_stamp + $urandom_range(1, 3000);
                end
                offer_sample(KIND_ANGLE, motor_angle, motor_stamp);
            end else if (pick < 84) begin
                offer_sample(KIND_VELOCITY, 12'($urandom_range(0, 4095)), $urandom);
            end else if (pick < 90) begin
                offer_sample(KIND_SPARE, 12'($urandom_range(0, 4095)), $urandom);
            end else begin
                kind  = KIND_BITS'($urandom_range(0, 3));
                angle = 12'($urandom_range(0, 4095));
                stamp = $urandom;
                if (kind == KIND_PRIME || kind == KIND_ANGLE) begin
                    motor_angle = angle;
                    motor_stamp = stamp;
                end
                offer_sample(kind, angle, stamp);
            end
        end
        wait_for_results();
    endtask

    initial begin
        i_rst_n           = 1'b0;
        cfg_we            = 1'b0;
        cfg_idx           = CFG_WRAP_THRESHOLD;
        cfg_data          = '0;
        in_ch.valid       = 1'b0;
        in_ch.kind        = KIND_PRIME;
        in_ch.angle_count = '0;
        in_ch.time_us     = '0;
        idling            = 1'b1;
        hold_req          = 1'b0;
        stall_cycles      = 0;
        motor_angle       = '0;
        motor_stamp       = $urandom;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        run_directed();
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                1: set_regs(12'd0, 20'd0);
                2: set_regs(12'd4095, 20'd1048575);
                3: set_regs(12'd2048, 20'd1);
                4: set_regs(12'($urandom_range(1, 4094)), 20'($urandom_range(2, 1048574)));
                5: set_regs(WRAP_RESET, INTERVAL_RESET);
                default: begin
                end
            endcase
            run_motion(PHASE_ITEMS, phase);
        end

        repeat (100) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("multiturn_angle_velocity_tracker test passed");
        end else begin
            $display("multiturn_angle_velocity_tracker test failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/avt_pkg.sv
rtl/avt_in_if.sv
rtl/avt_out_if.sv
rtl/avt_front.sv
rtl/avt_queue.sv
rtl/avt_back.sv
rtl/multiturn_angle_velocity_tracker.sv
tb/sv/multiturn_angle_velocity_tracker_checker.sv
tb/sv/multiturn_angle_velocity_tracker_tb.sv
